>>> sv/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants of the correlated point generator: payload
// structs, datapath operations, controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package cpg_pkg;

    // generator constants (64-bit LCG, MMIX multiplier and increment)
    localparam logic [63:0] LCG_MUL    = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD    = 64'd1442695040888963407;
    localparam int          LCG_SHIFT  = 16;
    localparam logic [63:0] SEED_RESET = 64'd42;

    // point length limit; dims and index widths below are sized for it
    localparam int MAX_DIMS = 16;

    // field widths
    localparam int COORD_W = 16;
    localparam int DIMS_W  = 5;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [DIMS_W-1:0]  DIMS_RESET = 5'd10;
    localparam logic [COORD_W-1:0] MAXV_RESET = 16'd1000;

    // restoring divider over the shifted generator word
    localparam int DIV_BITS = 64 - LCG_SHIFT;
    localparam int STEP_W   = $clog2(DIV_BITS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_DIMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd2;

    typedef struct packed {
        logic request;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] coordinate;
        logic [IDX_W-1:0]   dimension_index;
        logic               last_of_point;
    } t_res;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_ADD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FIX,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] dim_idx;
    } t_cmd;

    typedef struct packed {
        logic              out_busy;
        logic [DIMS_W-1:0] dims;
    } t_status;

endpackage

`default_nettype wire

>>> sv/cpg_stream_if.sv
// ----------------------------------------------------------------------------
// cpg_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/cpg_ctrl.sv
// ----------------------------------------------------------------------------
// cpg_ctrl
// Sequencer: per coordinate runs three partial products, the increment, a
// bit-serial remainder and the wrap, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  wire logic            i_req_bit,
    output logic                 o_req_ready,
    input  wire cpg_pkg::t_status i_status,
    output cpg_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ADD,
        S_DINIT,
        S_DIV,
        S_FIX,
        S_EMIT
    } t_state;

    t_state                        r_state, n_state;
    logic [cpg_pkg::DIMS_W-1:0]    r_dim, n_dim;
    logic [cpg_pkg::DIMS_W-1:0]    r_last_dim, n_last_dim;
    logic [cpg_pkg::STEP_W-1:0]    r_step, n_step;
    logic                          last;
    cpg_pkg::t_op                  op;

    assign last = (r_dim == r_last_dim);

    always_comb begin
        n_state    = r_state;
        n_dim      = r_dim;
        n_last_dim = r_last_dim;
        n_step     = r_step;
        op         = cpg_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_req_bit) begin
                    n_dim      = '0;
                    n_last_dim = i_status.dims - 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                op      = cpg_pkg::OP_MUL0;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                op      = cpg_pkg::OP_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                op      = cpg_pkg::OP_MUL2;
                n_state = S_ADD;
            end
            S_ADD: begin
                op      = cpg_pkg::OP_ADD;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                op      = cpg_pkg::OP_DIV_INIT;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                op     = cpg_pkg::OP_DIV_STEP;
                n_step = r_step + 1'b1;
                if (r_step == cpg_pkg::STEP_W'(cpg_pkg::DIV_BITS - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                op      = cpg_pkg::OP_FIX;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    op = cpg_pkg::OP_EMIT;
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dim   = r_dim + 1'b1;
                        n_state = S_MUL0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dim      <= '0;
            r_last_dim <= '0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_dim      <= n_dim;
            r_last_dim <= n_last_dim;
            r_step     <= n_step;
        end
    end

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_cmd.op      = op;
    assign o_cmd.first   = (r_dim == '0);
    assign o_cmd.last    = last;
    assign o_cmd.dim_idx = r_dim[cpg_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

>>> sv/cpg_dp.sv
// ----------------------------------------------------------------------------
// cpg_dp
// Datapath: configuration registers, generator state, shared 32x32
// multiplier, restoring remainder unit, wrap adder and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cpg_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire cpg_pkg::t_cmd                 i_cmd,
    output cpg_pkg::t_status                   o_status,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output cpg_pkg::t_res                      o_res_data
);

    logic [cpg_pkg::DIMS_W-1:0]   r_point_dims;
    logic [cpg_pkg::COORD_W-1:0]  r_max_value;
    logic [63:0]                  r_gen;
    logic [63:0]                  r_acc;
    logic [63:0]                  r_pp;
    logic [cpg_pkg::DIV_BITS-1:0] r_div;
    logic [cpg_pkg::COORD_W-1:0]  r_rem;
    logic [cpg_pkg::COORD_W-1:0]  r_mod;
    logic [cpg_pkg::COORD_W-1:0]  r_coord;
    logic                         r_out_valid;
    cpg_pkg::t_res                r_out;

    logic [cpg_pkg::DIMS_W-1:0]   dims_eff;
    logic [cpg_pkg::COORD_W-1:0]  m_eff;
    logic [cpg_pkg::COORD_W-1:0]  half;
    logic [31:0]                  mul_a, mul_b;
    logic [63:0]                  prod;
    logic [cpg_pkg::COORD_W:0]    trial;
    logic [cpg_pkg::COORD_W:0]    sum;

    always_comb begin
        if (r_point_dims == '0) begin
            dims_eff = cpg_pkg::DIMS_W'(1);
        end else if (32'(r_point_dims) > cpg_pkg::MAX_DIMS) begin
            dims_eff = cpg_pkg::DIMS_W'(cpg_pkg::MAX_DIMS);
        end else begin
            dims_eff = r_point_dims;
        end
    end

    assign m_eff = (r_max_value == '0) ? cpg_pkg::COORD_W'(1) : r_max_value;
    assign half  = (m_eff >> 1) + 1'b1;

    // low 64 bits of gen * MUL from three 32x32 partial products
    assign mul_a = (i_cmd.op == cpg_pkg::OP_MUL1) ? r_gen[63:32] : r_gen[31:0];
    assign mul_b = (i_cmd.op == cpg_pkg::OP_MUL2) ? cpg_pkg::LCG_MUL[63:32]
                                                  : cpg_pkg::LCG_MUL[31:0];
    assign prod  = mul_a * mul_b;

    assign trial = {r_rem, r_div[cpg_pkg::DIV_BITS-1]};
    assign sum   = (i_cmd.first ? '0 : {1'b0, r_coord}) + {1'b0, r_rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_dims <= cpg_pkg::DIMS_RESET;
            r_max_value  <= cpg_pkg::MAXV_RESET;
            r_gen        <= cpg_pkg::SEED_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cpg_pkg::CFG_POINT_DIMS: r_point_dims <= i_cfg_data[cpg_pkg::DIMS_W-1:0];
                    cpg_pkg::CFG_MAX_VALUE:  r_max_value  <= i_cfg_data[cpg_pkg::COORD_W-1:0];
                    cpg_pkg::CFG_SEED:       r_gen        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == cpg_pkg::OP_ADD) begin
                r_gen <= r_acc + {r_pp[31:0], 32'd0} + cpg_pkg::LCG_ADD;
            end
            if (i_cmd.op == cpg_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cpg_pkg::OP_MUL0: begin
                r_pp <= prod;
            end
            cpg_pkg::OP_MUL1: begin
                r_acc <= r_pp;
                r_pp  <= prod;
            end
            cpg_pkg::OP_MUL2: begin
                r_acc <= r_acc + {r_pp[31:0], 32'd0};
                r_pp  <= prod;
            end
            cpg_pkg::OP_DIV_INIT: begin
                r_div <= r_gen[63:cpg_pkg::LCG_SHIFT];
                r_rem <= '0;
                r_mod <= i_cmd.first ? m_eff : half;
            end
            cpg_pkg::OP_DIV_STEP: begin
                r_div <= r_div << 1;
                if (trial >= {1'b0, r_mod}) begin
                    r_rem <= cpg_pkg::COORD_W'(trial - {1'b0, r_mod});
                end else begin
                    r_rem <= trial[cpg_pkg::COORD_W-1:0];
                end
            end
            cpg_pkg::OP_FIX: begin
                // sum stays below 1.5 * modulus: one subtract wraps it
                if (sum >= {1'b0, m_eff}) begin
                    r_coord <= cpg_pkg::COORD_W'(sum - {1'b0, m_eff});
                end else begin
                    r_coord <= sum[cpg_pkg::COORD_W-1:0];
                end
            end
            cpg_pkg::OP_EMIT: begin
                r_out.coordinate      <= r_coord;
                r_out.dimension_index <= i_cmd.dim_idx;
                r_out.last_of_point   <= i_cmd.last;
            end
            default: ;
        endcase
    end

    assign o_status.out_busy = r_out_valid;
    assign o_status.dims     = dims_eff;
    assign o_res_valid       = r_out_valid;
    assign o_res_data        = r_out;

endmodule

`default_nettype wire

>>> sv/correlated_point_generator_top.sv
// ----------------------------------------------------------------------------
// correlated_point_generator_top
// Point generator: each request with the bit set yields one point of correlated
// coordinates from a 64-bit LCG, one result per coordinate, last one marked.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_req     in   valid/ready      request
//  o_res     out  valid/ready      coordinate, dimension_index, last_of_point
//  i_cfg_*   in   write enable     register index, 64-bit write data
//
//  Per coordinate the sequencer runs three partial products on the shared
//  32x32 multiplier, the increment, and a 48-step restoring remainder unit
//  that sets the pace, plus setup, wrap and handoff. A request with the bit
//  low is taken and dropped without producing a result.
//  Synchronous active-low reset loads the register defaults and seed 42.
//  A stalled output holds the sequencer before the next handoff only; the
//  next request is taken while the last result of a point still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module correlated_point_generator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    cpg_stream_if.sink                         i_req,
    cpg_stream_if.source                       o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [cpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cpg_pkg::CFG_W-1:0]     i_cfg_data
);

    cpg_pkg::t_cmd    cmd;
    cpg_pkg::t_status status;
    cpg_pkg::t_req    req_data;
    cpg_pkg::t_res    res_data;
    logic             req_ready;
    logic             res_valid;

    assign req_data    = i_req.data;
    assign i_req.ready = req_ready;
    assign o_res.valid = res_valid;
    assign o_res.data  = res_data;

    cpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_bit   (req_data.request),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cpg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res_data  (res_data)
    );

    // no datapath activity while a new request can be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_ready |-> (cmd.op == cpg_pkg::OP_NONE))
        else $error("datapath active while idle");

    // a new result appears only through a handoff
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!res_valid ##1 res_valid) |-> ($past(cmd.op) == cpg_pkg::OP_EMIT))
        else $error("result appeared without handoff");

    // handing off the last coordinate ends the point
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == cpg_pkg::OP_EMIT && cmd.last) |=> req_ready)
        else $error("sequencer did not return to idle after last coordinate");

    // a handoff never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == cpg_pkg::OP_EMIT) |-> !res_valid)
        else $error("handoff into a full output register");

endmodule

`default_nettype wire
